[sv/mvmp_pkg.sv]
// ----------------------------------------------------------------------------
// mvmp_pkg: shared types and constants for the mecanum motor packet block
// Field widths, fixed-point stage widths, packet byte codes and register
// indexes used by the kinematics front end, the queue and the serializer.
// ----------------------------------------------------------------------------
package mvmp_pkg;

   localparam int NUM_MOTORS = 4;
   localparam int MOTOR_W    = 2;

   // Field widths
   localparam int VEL_W   = 16;
   localparam int COEFF_W = 20;
   localparam int CORR_W  = 16;
   localparam int LIM_W   = 15;
   localparam int RPM_W   = 16;
   localparam int BYTE_W  = 8;
   localparam int POS_W   = 4;
   localparam int ID_W    = 3;

   // Fixed-point datapath widths
   localparam int WHEEL_W = VEL_W + 1 + COEFF_W + 1;   // 38, Q.22 wheel term
   localparam int LO_W    = 18;                        // low slice of the split multiply
   localparam int PPHI_W  = WHEEL_W - LO_W + CORR_W;   // 36
   localparam int PPLO_W  = LO_W + CORR_W;             // 34
   localparam int PROD_W  = PPHI_W + LO_W;             // 54, Q.36 product
   localparam int FRAC_W  = 36;
   localparam int MAG_W   = PROD_W - FRAC_W;           // 18

   localparam int FRONT_STAGES     = 6;
   localparam int QUEUE_DEPTH_DEF  = 4;

   // Motors whose rpm is sent with inverted sign (front left, rear left)
   localparam logic [NUM_MOTORS-1:0] FLIP_MASK = 4'b0101;

   // Packet layout
   localparam logic [POS_W-1:0] POS_ID     = 4'd0;
   localparam logic [POS_W-1:0] POS_CMD    = 4'd1;
   localparam logic [POS_W-1:0] POS_RPM_HI = 4'd2;
   localparam logic [POS_W-1:0] POS_RPM_LO = 4'd3;
   localparam logic [POS_W-1:0] POS_MODE   = 4'd6;
   localparam logic [POS_W-1:0] POS_CRC    = 4'd9;

   localparam logic [BYTE_W-1:0] PKT_CMD  = 8'h64;
   localparam logic [BYTE_W-1:0] PKT_MODE = 8'h0A;
   localparam logic [BYTE_W-1:0] PKT_ZERO = 8'h00;
   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;
   localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

   // Register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_LINEAR_COEFF     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ANGULAR_COEFF    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CORR_FRONT_LEFT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CORR_FRONT_RIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CORR_REAR_LEFT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CORR_REAR_RIGHT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RPM_LIMIT        = 3'd6;
   localparam int CSR_DATA_W = COEFF_W;

   // Register reset values
   localparam logic [COEFF_W-1:0] LINEAR_COEFF_RST  = 20'd488924;
   localparam logic [COEFF_W-1:0] ANGULAR_COEFF_RST = 20'd371582;
   localparam logic [CORR_W-1:0]  CORR_RST          = 16'd16384;
   localparam logic [LIM_W-1:0]   RPM_LIMIT_RST     = 15'd330;

   typedef logic [NUM_MOTORS-1:0][RPM_W-1:0] rpm_set_type;

   typedef struct packed {
      logic [COEFF_W-1:0]                 linear_coeff;
      logic [COEFF_W-1:0]                 angular_coeff;
      logic [NUM_MOTORS-1:0][CORR_W-1:0]  corr;
      logic [LIM_W-1:0]                   rpm_limit;
   } cfg_type;

   typedef struct packed {
      logic        push;
      rpm_set_type rpm;
   } front_out_type;

endpackage

[sv/mvmp_front.sv]
// ----------------------------------------------------------------------------
// mvmp_front: mecanum kinematics pipeline
// Six-stage pipeline turning one velocity command into four clamped wheel rpm
// values; one item may enter every cycle.
// ----------------------------------------------------------------------------
module mvmp_front
   import mvmp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start_i,
   input  logic signed [VEL_W-1:0] vel_x_i,
   input  logic signed [VEL_W-1:0] vel_y_i,
   input  logic signed [VEL_W-1:0] yaw_rate_i,
   input  cfg_type                 cfg_i,
   output front_out_type           out_o
);

   logic [FRONT_STAGES-1:0] valid_ff, valid_in;

   logic signed [VEL_W:0]     sum_xy, dif_xy;
   logic signed [WHEEL_W-1:0] prod_sum_ff, prod_sum_in;
   logic signed [WHEEL_W-1:0] prod_dif_ff, prod_dif_in;
   logic signed [WHEEL_W-1:0] prod_yaw_ff, prod_yaw_in;

   logic signed [WHEEL_W-1:0] wheel_ff [NUM_MOTORS];
   logic signed [WHEEL_W-1:0] wheel_in [NUM_MOTORS];
   logic signed [PPHI_W-1:0]  pp_hi_ff [NUM_MOTORS];
   logic signed [PPHI_W-1:0]  pp_hi_in [NUM_MOTORS];
   logic        [PPLO_W-1:0]  pp_lo_ff [NUM_MOTORS];
   logic        [PPLO_W-1:0]  pp_lo_in [NUM_MOTORS];
   logic signed [PROD_W-1:0]  prod_ff  [NUM_MOTORS];
   logic signed [PROD_W-1:0]  prod_in  [NUM_MOTORS];
   logic        [PROD_W-1:0]  abs_val  [NUM_MOTORS];
   logic        [MAG_W-1:0]   mag_ff   [NUM_MOTORS];
   logic        [MAG_W-1:0]   mag_in   [NUM_MOTORS];
   logic        [NUM_MOTORS-1:0] neg_ff, neg_in;
   logic        [LIM_W-1:0]   clamp_val [NUM_MOTORS];
   rpm_set_type               rpm_ff, rpm_in;

   assign valid_in = {valid_ff[FRONT_STAGES-2:0], start_i};

   // Stage 1: linear and yaw products
   always_comb begin
      sum_xy      = $signed({vel_x_i[VEL_W-1], vel_x_i}) + $signed({vel_y_i[VEL_W-1], vel_y_i});
      dif_xy      = $signed({vel_x_i[VEL_W-1], vel_x_i}) - $signed({vel_y_i[VEL_W-1], vel_y_i});
      prod_sum_in = sum_xy * $signed({1'b0, cfg_i.linear_coeff});
      prod_dif_in = dif_xy * $signed({1'b0, cfg_i.linear_coeff});
      prod_yaw_in = yaw_rate_i * $signed({1'b0, cfg_i.angular_coeff});
   end

   // Stage 2: wheel terms
   always_comb begin
      wheel_in[0] = prod_dif_ff - prod_yaw_ff;
      wheel_in[1] = -(prod_sum_ff + prod_yaw_ff);
      wheel_in[2] = prod_sum_ff - prod_yaw_ff;
      wheel_in[3] = -(prod_dif_ff + prod_yaw_ff);
   end

   // Stages 3 to 6, one lane per motor
   always_comb begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
         pp_hi_in[m] = $signed(wheel_ff[m][WHEEL_W-1:LO_W]) * $signed({1'b0, cfg_i.corr[m]});
         pp_lo_in[m] = wheel_ff[m][LO_W-1:0] * cfg_i.corr[m];
         prod_in[m]  = $signed({pp_hi_ff[m], {LO_W{1'b0}}})
                     + $signed({{(PROD_W-PPLO_W){1'b0}}, pp_lo_ff[m]});
         neg_in[m]   = prod_ff[m][PROD_W-1];
         abs_val[m]  = neg_in[m] ? PROD_W'(-prod_ff[m]) : PROD_W'(prod_ff[m]);
         mag_in[m]   = abs_val[m][PROD_W-1:FRAC_W];
         clamp_val[m] = (mag_ff[m] > MAG_W'(cfg_i.rpm_limit)) ? cfg_i.rpm_limit
                                                             : mag_ff[m][LIM_W-1:0];
         rpm_in[m]   = (neg_ff[m] ^ FLIP_MASK[m]) ? (RPM_W'(0) - {1'b0, clamp_val[m]})
                                                  : {1'b0, clamp_val[m]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_sum_ff <= prod_sum_in;
      prod_dif_ff <= prod_dif_in;
      prod_yaw_ff <= prod_yaw_in;
      wheel_ff    <= wheel_in;
      pp_hi_ff    <= pp_hi_in;
      pp_lo_ff    <= pp_lo_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      rpm_ff      <= rpm_in;
   end

   assign out_o.push = valid_ff[FRONT_STAGES-1];
   assign out_o.rpm  = rpm_ff;

endmodule

[sv/mvmp_queue.sv]
// ----------------------------------------------------------------------------
// mvmp_queue: rpm set queue between kinematics and serializer
// Small FIFO of rpm sets; a slot is reserved when an item enters the
// pipeline so a pushed set always finds room.
// ----------------------------------------------------------------------------
module mvmp_queue
   import mvmp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          reserve_i,
   input  front_out_type in_i,
   input  logic          pop_i,
   output logic          room_o,
   output logic          valid_o,
   output rpm_set_type   data_o
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rpm_set_type      mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;   // sets stored
   logic [CNT_W-1:0] occ_ff, occ_in;   // sets stored plus sets in flight

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (in_i.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_i) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + CNT_W'(in_i.push) - CNT_W'(pop_i);
      occ_in = occ_ff + CNT_W'(reserve_i) - CNT_W'(pop_i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
         occ_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
         occ_ff    <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_i.push) begin
         mem[wr_ptr_ff] <= in_i.rpm;
      end
   end

   assign room_o  = (occ_ff < CNT_W'(DEPTH));
   assign valid_o = (cnt_ff != '0);
   assign data_o  = mem[rd_ptr_ff];

`ifndef SYNTHESIS
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      in_i.push |-> (cnt_ff < CNT_W'(DEPTH)) || pop_i)
      else $error("queue push with no free slot");

   a_stored_within_reserved: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= occ_ff)
      else $error("queue holds more sets than were reserved");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      pop_i |-> valid_o)
      else $error("queue popped while empty");
`endif

endmodule

[sv/mvmp_back.sv]
// ----------------------------------------------------------------------------
// mvmp_back: motor packet serializer
// Walks one rpm set through four 10-byte packets with a running CRC-8
// (reflected 0x8C) and an output register; one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module mvmp_back
   import mvmp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid_i,
   input  rpm_set_type       q_data_i,
   output logic              pop_o,
   input  logic              rsp_ready_i,
   output logic              rsp_valid_o,
   output logic [BYTE_W-1:0] rsp_packet_byte_o,
   output logic [ID_W-1:0]   rsp_motor_number_o,
   output logic [POS_W-1:0]  rsp_byte_position_o,
   output logic              rsp_last_byte_o
);

   function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int b = 0; b < BYTE_W; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   logic              cur_valid_ff, cur_valid_in;
   rpm_set_type       cur_rpm_ff, cur_rpm_in;
   logic [MOTOR_W-1:0] motor_ff, motor_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] crc_ff, crc_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic [ID_W-1:0]   rsp_motor_ff;
   logic [POS_W-1:0]  rsp_pos_ff;
   logic              rsp_last_ff;

   logic              advance, emit, at_last, done;
   logic [BYTE_W-1:0] byte_val;
   logic [RPM_W-1:0]  rpm_cur;
   logic [ID_W-1:0]   motor_num;

   assign rpm_cur   = cur_rpm_ff[motor_ff];
   assign motor_num = ID_W'(motor_ff) + 1'b1;
   assign at_last   = (motor_ff == MOTOR_W'(NUM_MOTORS - 1)) && (pos_ff == POS_CRC);
   assign advance   = !rsp_valid_ff || rsp_ready_i;
   assign emit      = advance && cur_valid_ff;
   assign done      = emit && at_last;
   assign pop_o     = q_valid_i && (!cur_valid_ff || done);

   always_comb begin
      unique case (pos_ff)
         POS_ID:     byte_val = BYTE_W'(motor_num);
         POS_CMD:    byte_val = PKT_CMD;
         POS_RPM_HI: byte_val = rpm_cur[RPM_W-1:BYTE_W];
         POS_RPM_LO: byte_val = rpm_cur[BYTE_W-1:0];
         POS_MODE:   byte_val = PKT_MODE;
         POS_CRC:    byte_val = crc_ff;
         default:    byte_val = PKT_ZERO;
      endcase
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_rpm_in   = cur_rpm_ff;
      motor_in     = motor_ff;
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      if (emit) begin
         crc_in = crc8_step((pos_ff == POS_ID) ? CRC_INIT : crc_ff, byte_val);
         if (pos_ff == POS_CRC) begin
            pos_in   = POS_ID;
            motor_in = motor_ff + 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
      // load the next set, or go idle after the final byte
      if (pop_o) begin
         cur_valid_in = 1'b1;
         cur_rpm_in   = q_data_i;
         motor_in     = '0;
         pos_in       = POS_ID;
      end else if (done) begin
         cur_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? cur_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         motor_ff     <= '0;
         pos_ff       <= POS_ID;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         motor_ff     <= motor_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_rpm_ff <= cur_rpm_in;
      crc_ff     <= crc_in;
      if (advance) begin
         rsp_byte_ff  <= byte_val;
         rsp_motor_ff <= motor_num;
         rsp_pos_ff   <= pos_ff;
         rsp_last_ff  <= at_last;
      end
   end

   assign rsp_valid_o         = rsp_valid_ff;
   assign rsp_packet_byte_o   = rsp_byte_ff;
   assign rsp_motor_number_o  = rsp_motor_ff;
   assign rsp_byte_position_o = rsp_pos_ff;
   assign rsp_last_byte_o     = rsp_last_ff;

`ifndef SYNTHESIS
   a_pos_in_packet: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_CRC)
      else $error("byte position beyond packet end");

   a_id_byte_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_pos_ff == POS_ID) |-> rsp_byte_ff == BYTE_W'(rsp_motor_ff))
      else $error("id byte differs from motor number");

   a_last_ends_set: assert property (@(posedge clock) disable iff (reset)
      done && !q_valid_i |=> !cur_valid_ff)
      else $error("serializer still busy after the final byte");
`endif

endmodule

[sv/mecanum_velocity_to_motor_packets.sv]
// ----------------------------------------------------------------------------
// mecanum_velocity_to_motor_packets: velocity command to motor packet stream
// Mecanum inverse kinematics with CRC-8 framed packets for four wheel motors.
// ----------------------------------------------------------------------------
// Each velocity command (vel_x, vel_y, yaw_rate, signed Q5.10) taken on the
// req_ channel becomes 40 bytes on the rsp_ channel: one 10-byte packet per
// motor in the order front left, front right, rear left, rear right, each
// carrying id, 0x64, rpm high, rpm low, five fixed bytes and a CRC-8 over the
// first nine bytes; last_byte marks the 40th byte. Bytes leave one per
// cycle while rsp_ready is high, so the byte serializer sets the sustained
// command rate. The kinematics pipeline itself takes a new command every
// cycle, and up to QUEUE_DEPTH commands (counting those still in the
// pipeline) wait ahead of the serializer before req_ready drops.
// Configuration registers (index: 0 linear_coeff, 1 angular_coeff, 2..5
// per-motor corrections FL/FR/RL/RR, 6 rpm_limit) are written through the
// csr_ channel, which is always ready; write them only while the block is
// idle. Writes to other indexes are ignored.
// ----------------------------------------------------------------------------
module mecanum_velocity_to_motor_packets
   import mvmp_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [VEL_W-1:0] req_vel_x,
   input  logic signed [VEL_W-1:0] req_vel_y,
   input  logic signed [VEL_W-1:0] req_yaw_rate,

   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [BYTE_W-1:0]       rsp_packet_byte,
   output logic [ID_W-1:0]         rsp_motor_number,
   output logic [POS_W-1:0]        rsp_byte_position,
   output logic                    rsp_last_byte,

   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   front_out_type front_out;
   rpm_set_type   q_data;
   logic          q_room, q_valid, q_pop;
   logic          req_take;

   // Configuration registers; mask the write data to each register's width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_LINEAR_COEFF:     cfg_in.linear_coeff  = csr_wdata[COEFF_W-1:0];
            REG_ANGULAR_COEFF:    cfg_in.angular_coeff = csr_wdata[COEFF_W-1:0];
            REG_CORR_FRONT_LEFT:  cfg_in.corr[0]       = csr_wdata[CORR_W-1:0];
            REG_CORR_FRONT_RIGHT: cfg_in.corr[1]       = csr_wdata[CORR_W-1:0];
            REG_CORR_REAR_LEFT:   cfg_in.corr[2]       = csr_wdata[CORR_W-1:0];
            REG_CORR_REAR_RIGHT:  cfg_in.corr[3]       = csr_wdata[CORR_W-1:0];
            REG_RPM_LIMIT:        cfg_in.rpm_limit     = csr_wdata[LIM_W-1:0];
            default:              cfg_in = cfg_ff;  // drop writes to unknown indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.linear_coeff  <= LINEAR_COEFF_RST;
         cfg_ff.angular_coeff <= ANGULAR_COEFF_RST;
         cfg_ff.corr          <= {NUM_MOTORS{CORR_RST}};
         cfg_ff.rpm_limit     <= RPM_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   // Admit an item only when a queue slot is free for its rpm set
   assign req_ready = q_room;
   assign req_take  = req_valid && q_room;

   mvmp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start_i    (req_take),
      .vel_x_i    (req_vel_x),
      .vel_y_i    (req_vel_y),
      .yaw_rate_i (req_yaw_rate),
      .cfg_i      (cfg_ff),
      .out_o      (front_out)
   );

   mvmp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .reserve_i (req_take),
      .in_i      (front_out),
      .pop_i     (q_pop),
      .room_o    (q_room),
      .valid_o   (q_valid),
      .data_o    (q_data)
   );

   mvmp_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid_i           (q_valid),
      .q_data_i            (q_data),
      .pop_o               (q_pop),
      .rsp_ready_i         (rsp_ready),
      .rsp_valid_o         (rsp_valid),
      .rsp_packet_byte_o   (rsp_packet_byte),
      .rsp_motor_number_o  (rsp_motor_number),
      .rsp_byte_position_o (rsp_byte_position),
      .rsp_last_byte_o     (rsp_last_byte)
   );

endmodule
